@@ rtl/u8v_pkg.sv @@
// u8v_pkg: shared types, constants and byte-class functions for the utf-8 validator
// no dependencies; used by u8v_step, utf8_stream_validator and u8v_checker
`default_nettype none

package u8v_pkg;

  // trail byte counts announced by a lead byte
  localparam logic [2:0] TRAILS_NONE = 3'd0;
  localparam logic [2:0] TRAILS_2B   = 3'd1;
  localparam logic [2:0] TRAILS_3B   = 3'd2;
  localparam logic [2:0] TRAILS_4B   = 3'd3;
  localparam logic [2:0] TRAILS_5B   = 3'd4;
  localparam logic [2:0] TRAILS_6B   = 3'd5;
  localparam logic [2:0] LEAD_BAD    = 3'd7;
  localparam logic [2:0] TRAILS_MAX  = TRAILS_6B;

  localparam logic [7:0] OVL_2B_MASK   = 8'h1E;
  localparam logic [7:0] SURR_LEAD     = 8'hED;
  localparam logic [7:0] SURR_MASK     = 8'hA0;
  localparam logic [7:0] OVL_3B_LMASK  = 8'h0F;
  localparam logic [7:0] OVL_3B_SMASK  = 8'h20;
  localparam logic [7:0] OVL_4B_LMASK  = 8'h07;
  localparam logic [7:0] OVL_4B_SMASK  = 8'h30;
  localparam logic [7:0] OVL_5B_LMASK  = 8'h03;
  localparam logic [7:0] OVL_5B_SMASK  = 8'h38;
  localparam logic [7:0] OVL_6B_LMASK  = 8'h01;
  localparam logic [7:0] OVL_6B_SMASK  = 8'h3E;
  localparam logic [7:0] TRAIL_MASK    = 8'hC0;
  localparam logic [7:0] TRAIL_TAG     = 8'h80;

  typedef struct packed {
    logic [2:0] trail_left;
    logic [7:0] lead_kept;
    logic       at_second;
    logic       error_seen;
  } u8v_state_t;

  typedef struct packed {
    u8v_state_t state;
    logic       text_valid;
  } u8v_step_t;

  // trail count for a lead byte, or LEAD_BAD
  function automatic logic [2:0] lead_trails(input logic [7:0] b);
    logic [2:0] n;
    if (b[7] == 1'b0)              n = TRAILS_NONE;
    else if (b[7:5] == 3'b110)     n = TRAILS_2B;
    else if (b[7:4] == 4'b1110)    n = TRAILS_3B;
    else if (b[7:3] == 5'b11110)   n = TRAILS_4B;
    else if (b[7:2] == 6'b111110)  n = TRAILS_5B;
    else if (b[7:1] == 7'b1111110) n = TRAILS_6B;
    else                           n = LEAD_BAD;
    return n;
  endfunction

  // overlong form or surrogate, judged from lead and second byte
  function automatic logic second_bad(input logic [7:0] lead, input logic [7:0] b);
    logic bad;
    case (lead_trails(lead))
      TRAILS_3B: bad = ((lead == SURR_LEAD) && ((b & SURR_MASK) == SURR_MASK)) ||
                       (((lead & OVL_3B_LMASK) == 8'h00) && ((b & OVL_3B_SMASK) == 8'h00));
      TRAILS_4B: bad = ((lead & OVL_4B_LMASK) == 8'h00) && ((b & OVL_4B_SMASK) == 8'h00);
      TRAILS_5B: bad = ((lead & OVL_5B_LMASK) == 8'h00) && ((b & OVL_5B_SMASK) == 8'h00);
      TRAILS_6B: bad = ((lead & OVL_6B_LMASK) == 8'h00) && ((b & OVL_6B_SMASK) == 8'h00);
      default:   bad = 1'b0;
    endcase
    return bad;
  endfunction

endpackage

`default_nettype wire

@@ rtl/u8v_if.sv @@
// u8v_if: valid/ready channel interfaces for the byte input and the verdict output
// no dependencies
`default_nettype none

interface u8v_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8v_out_if;
  logic valid;
  logic ready;
  logic text_valid;

  modport source (output valid, output text_valid, input ready);
  modport sink   (input valid, input text_valid, output ready);
endinterface

`default_nettype wire

@@ rtl/u8v_step.sv @@
// u8v_step: next decoder state and verdict for one byte
// depends on u8v_pkg
`default_nettype none

module u8v_step
  import u8v_pkg::*;
(
  input  wire u8v_state_t cur,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output u8v_step_t       step
);

  logic [2:0] n;
  u8v_state_t nxt;

  always_comb begin
    n   = lead_trails(data_byte);
    nxt = cur;
    if (cur.trail_left == TRAILS_NONE) begin
      // lead position
      if (n == LEAD_BAD) begin
        nxt.error_seen = 1'b1;
        nxt.trail_left = TRAILS_NONE;
      end else begin
        if ((n == TRAILS_2B) && ((data_byte & OVL_2B_MASK) == 8'h00)) begin
          nxt.error_seen = 1'b1;
        end
        nxt.trail_left = n;
      end
      nxt.lead_kept = data_byte;
      nxt.at_second = (n != TRAILS_NONE) && (n != LEAD_BAD);
    end else begin
      // trail position
      if ((data_byte & TRAIL_MASK) != TRAIL_TAG) begin
        nxt.error_seen = 1'b1;
      end
      if (cur.at_second && second_bad(cur.lead_kept, data_byte)) begin
        nxt.error_seen = 1'b1;
      end
      nxt.at_second  = 1'b0;
      nxt.trail_left = cur.trail_left - 3'd1;
    end

    step.text_valid = !nxt.error_seen && (nxt.trail_left == TRAILS_NONE);
    if (last_byte) begin
      step.state = '0;
    end else begin
      step.state = nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/utf8_stream_validator.sv @@
// utf8_stream_validator: top level, checks a byte stream as legacy 1..6 byte utf-8
// depends on u8v_pkg, u8v_if (u8v_in_if, u8v_out_if) and u8v_step
//
//   channel   dir  payload                       item
//   in_chan   in   data_byte[7:0], last_byte     one byte of the text
//   out_chan  out  text_valid                    one verdict per text, on its last byte
//
// one byte per cycle sustained while verdicts are taken: input register, then the
// decode step, then the verdict register; a byte waits in the input register until
// it updates the decoder, and a last byte loads the verdict register, where it is taken
// reset clears the input valid bit, the decoder state and the verdict valid bit at once
// a stalled verdict holds the last byte of the next text in the input register;
// bytes that end no text keep flowing while a verdict waits
`default_nettype none

module utf8_stream_validator
  import u8v_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  u8v_in_if.sink        in_chan,
  u8v_out_if.source     out_chan
);

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // decoder state and verdict register
  u8v_state_t state_r;
  logic       out_valid_r;
  logic       text_valid_r;

  u8v_step_t  step;
  logic       out_free;
  logic       s1_fire;
  logic       in_fire;

  // verdict slot is free when empty or being taken this cycle
  assign out_free = !out_valid_r || out_chan.ready;
  // a byte leaves the input register unless it needs a busy verdict slot
  assign s1_fire  = s1_valid_r && (!s1_last_r || out_free);
  assign in_chan.ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_chan.valid && in_chan.ready;

  u8v_step u_step (
    .cur       (state_r),
    .data_byte (s1_byte_r),
    .last_byte (s1_last_r),
    .step      (step)
  );

  // byte register: valid bit under reset, payload loaded only on an accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_chan.data_byte;
      s1_last_r <= in_chan.last_byte;
    end
  end

  // decoder state advances once per byte; last byte returns it to reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_fire) begin
      state_r <= step.state;
    end
  end

  // verdict register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      text_valid_r <= step.text_valid;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.text_valid = text_valid_r;

  // end of text leaves the decoder in its reset state
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |=> (state_r == '0))
    else $error("decoder state not cleared after last byte");

  // trail count never beyond a six byte sequence
  a_trail_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.trail_left <= TRAILS_MAX)
    else $error("trail count out of range");

  // second-byte flag only while trail bytes are pending
  a_second_needs_trail: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.at_second |-> (state_r.trail_left != TRAILS_NONE))
    else $error("second-byte flag without pending trail");

  // a verdict appears only after a last byte went through the decoder
  a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_fire && s1_last_r))
    else $error("verdict without a last byte");

  // last byte never overwrites a waiting verdict
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_last_r) |-> (!out_valid_r || out_chan.ready))
    else $error("verdict overwritten while stalled");

endmodule

`default_nettype wire

@@ tb/u8v_checker.sv @@
// u8v_checker: watches both validator channels, predicts each text verdict and compares
// depends on u8v_pkg and the channel interfaces u8v_in_if and u8v_out_if
module u8v_checker
  import u8v_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  u8v_in_if         in_mon,
  u8v_out_if        out_mon,
  output int        fail_count,
  output int        verdicts_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // decoder state of the text in progress
  logic [2:0] trails_due;
  logic [7:0] seq_lead;
  logic       want_second;
  logic       text_broken;

  logic       verdict_q[$];
  logic       verdict_exp;

  // trail count that a lead byte announces, LEAD_BAD for 80..BF, FE, FF
  function automatic logic [2:0] seq_trails(input logic [7:0] b);
    casez (b)
      8'b0???????: return TRAILS_NONE;
      8'b110?????: return TRAILS_2B;
      8'b1110????: return TRAILS_3B;
      8'b11110???: return TRAILS_4B;
      8'b111110??: return TRAILS_5B;
      8'b1111110?: return TRAILS_6B;
      default:     return LEAD_BAD;
    endcase
  endfunction

  // overlong form of 3..6 byte sequences, or ED A0..BF surrogate
  function automatic logic pair_is_overlong(input logic [7:0] lead, input logic [7:0] b);
    logic [7:0] lmask;
    logic [7:0] smask;
    logic       judged;
    logic       surrogate;
    judged    = 1'b1;
    surrogate = 1'b0;
    lmask     = '0;
    smask     = '0;
    case (seq_trails(lead))
      TRAILS_3B: begin
        lmask     = OVL_3B_LMASK;
        smask     = OVL_3B_SMASK;
        surrogate = (lead == SURR_LEAD) && ((b & SURR_MASK) == SURR_MASK);
      end
      TRAILS_4B: begin
        lmask = OVL_4B_LMASK;
        smask = OVL_4B_SMASK;
      end
      TRAILS_5B: begin
        lmask = OVL_5B_LMASK;
        smask = OVL_5B_SMASK;
      end
      TRAILS_6B: begin
        lmask = OVL_6B_LMASK;
        smask = OVL_6B_SMASK;
      end
      default: judged = 1'b0;
    endcase
    return judged && (surrogate || (((lead & lmask) == 8'h00) && ((b & smask) == 8'h00)));
  endfunction

  task automatic clear_text();
    trails_due  = TRAILS_NONE;
    seq_lead    = 8'h00;
    want_second = 1'b0;
    text_broken = 1'b0;
  endtask

  // advance the decoder by one byte; the final byte yields a verdict
  task automatic decode_byte(input logic [7:0] b, input logic fin);
    logic [2:0] n;
    if (trails_due == TRAILS_NONE) begin
      n = seq_trails(b);
      if (n == LEAD_BAD) begin
        text_broken = 1'b1;
        n = TRAILS_NONE;
      end else if (n == TRAILS_2B && (b & OVL_2B_MASK) == 8'h00) begin
        text_broken = 1'b1;
      end
      trails_due  = n;
      seq_lead    = b;
      want_second = (n != TRAILS_NONE);
    end else begin
      if ((b & TRAIL_MASK) != TRAIL_TAG) text_broken = 1'b1;
      if (want_second && pair_is_overlong(seq_lead, b)) text_broken = 1'b1;
      want_second = 1'b0;
      trails_due  = trails_due - 3'd1;
    end
    if (fin) begin
      verdict_q.push_back(!text_broken && trails_due == TRAILS_NONE);
      clear_text();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_text();
      verdict_q.delete();
      fail_count    <= 0;
      verdicts_owed <= 0;
    end else begin
      // a verdict can never stem from a byte taken at the same edge
      if (out_mon.valid && out_mon.ready) begin
        if (verdict_q.size() == 0) begin
          $error("text_valid: expected no verdict, actual %0b", out_mon.text_valid);
          fail_count <= fail_count + 1;
        end else begin
          verdict_exp = verdict_q.pop_front();
          if (out_mon.text_valid !== verdict_exp) begin
            $error("text_valid: expected %0b, actual %0b", verdict_exp, out_mon.text_valid);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) decode_byte(in_mon.data_byte, in_mon.last_byte);
      verdicts_owed <= verdict_q.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
// tb_top: stimulus, handshake idling and verdict for the utf-8 stream validator
// depends on u8v_pkg, u8v_in_if, u8v_out_if, utf8_stream_validator and u8v_checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 1600;  // stimulus stops once this many bytes went in
  localparam int CALM_BYTES   = 1350;  // from here on neither side idles
  localparam int STALL_LIMIT  = 1000;  // cycles without any accepted item
  localparam int DRAIN_CYCLES = 8;     // two-stage pipe plus margin

  logic clk = 1'b0;
  logic rst_n;

  u8v_in_if  in_chan();
  u8v_out_if out_chan();

  int fail_count;
  int verdicts_owed;
  int bytes_sent;
  int quiet_cycles;
  bit calm;

  logic [7:0] text_bytes[$];

  utf8_stream_validator uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  u8v_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .fail_count    (fail_count),
    .verdicts_owed (verdicts_owed)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog: any handshake on either side counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // verdict receiver: ready runs of random length, then now and then a stall burst
  initial begin
    int run_len;
    int stall_len;
    out_chan.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 20);
      repeat (run_len) begin
        @(negedge clk);
        out_chan.ready <= 1'b1;
      end
      if (!calm && $urandom_range(0, 1) == 0) begin
        stall_len = $urandom_range(1, 11);
        repeat (stall_len) begin
          @(negedge clk);
          out_chan.ready <= 1'b0;
        end
      end
    end
  end

  // one byte onto the input channel, with an optional idle burst in front;
  // returns at the rising edge where the byte was taken
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap_len;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap_len = $urandom_range(1, 11);
      repeat (gap_len) begin
        @(negedge clk);
        in_chan.valid     <= 1'b0;
        in_chan.data_byte <= 8'($urandom);   // junk while idle must be ignored
        in_chan.last_byte <= 1'($urandom_range(0, 1));
      end
    end
    @(negedge clk);
    in_chan.valid     <= 1'b1;
    in_chan.data_byte <= b;
    in_chan.last_byte <= fin;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    bytes_sent++;
    if (bytes_sent >= CALM_BYTES) calm = 1'b1;
  endtask

  // whole text, flag on its final byte
  task automatic send_text();
    foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
  endtask

  // one character: well-formed sequence of 1..6 bytes with random payload,
  // sometimes squeezed toward overlong forms, sometimes damaged
  task automatic add_char();
    int         pick;
    int         len;
    int         k;
    bit         minimal;
    logic [7:0] prefix;
    logic [7:0] payload_mask;
    logic [7:0] char_bytes[$];
    pick    = $urandom_range(0, 19);
    len     = (pick < 8) ? 1 : (pick < 12) ? 2 : (pick < 16) ? 3 : (pick < 18) ? 4 :
              (pick < 19) ? 5 : 6;
    minimal = ($urandom_range(0, 3) == 0);
    if (len == 1) begin
      char_bytes.push_back(8'($urandom) & 8'h7F);
    end else begin
      prefix       = 8'hFF << (8 - len);
      payload_mask = 8'hFF >> (len + 1);
      // minimal payload makes the overlong checks fire far more often
      if (minimal) payload_mask = 8'h01;
      char_bytes.push_back(prefix | (8'($urandom) & payload_mask));
      for (k = 1; k < len; k++) begin
        if (minimal && k == 1) char_bytes.push_back(8'h80 | 8'($urandom_range(0, 1)));
        else char_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 2))
        0: char_bytes[$urandom_range(0, char_bytes.size() - 1)] = 8'($urandom);  // bad byte
        1: if (char_bytes.size() > 1)                                          // cut short
             char_bytes = char_bytes[0:$urandom_range(0, char_bytes.size() - 2)];
        default: char_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));     // stray trail
      endcase
    end
    foreach (char_bytes[i]) text_bytes.push_back(char_bytes[i]);
  endtask

  initial begin
    in_chan.valid     <= 1'b0;
    in_chan.data_byte <= 8'h00;
    in_chan.last_byte <= 1'b0;
    rst_n             <= 1'b0;
    bytes_sent        = 0;
    calm              = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed texts: byte extremes, 1-, 2-, 3- and 6-byte sequences and each error kind
    text_bytes = '{8'h00};                               // lowest byte, valid
    send_text();
    text_bytes = '{8'h7F};                               // top of ascii, valid
    send_text();
    text_bytes = '{8'hC2, 8'h80};                        // smallest proper 2-byte
    send_text();
    text_bytes = '{8'hC0, 8'h80};                        // overlong 2-byte lead
    send_text();
    text_bytes = '{8'hED, 8'hA0, 8'h80};                 // surrogate
    send_text();
    text_bytes = '{8'hE0, 8'h80, 8'h80};                 // overlong 3-byte
    send_text();
    text_bytes = '{8'hFC, 8'h84, 8'h80, 8'h80, 8'h80, 8'h80};  // proper 6-byte
    send_text();
    text_bytes = '{8'hFF};                               // invalid lead, top byte
    send_text();
    text_bytes = '{8'hC3, 8'h41};                        // bad trail byte
    send_text();
    text_bytes = '{8'hE4, 8'hB8};                        // text ends mid-sequence
    send_text();

    // random texts, mostly built from characters, some pure noise
    while (bytes_sent < RANDOM_BYTES) begin
      text_bytes.delete();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 10)) text_bytes.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 8)) add_char();
      end
      send_text();
    end
    @(negedge clk);
    in_chan.valid <= 1'b0;

    // drain: every verdict back, then let the pipe settle
    while (verdicts_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
